// ===== sv/vmrb_pkg.sv =====
// ----------------------------------------------------------------------------
// vmrb_pkg
// Shared types, register offsets and constants of the virtio-mmio register
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package vmrb_pkg;

  localparam int VMRB_QUEUE_COUNT   = 8;
  localparam int VMRB_MAX_RING_SIZE = 256;

  localparam logic [31:0] MAGIC_CODE     = 32'h7472_6976;
  localparam logic [31:0] VERSION_CODE   = 32'd2;
  localparam logic [15:0] VENDOR_CODE    = 16'hf003;
  localparam int          EVENT_IDX_BIT  = 29;

  localparam logic [63:0] OFFERED_RESET  = 64'h0000_0001_2000_0000;
  localparam logic [15:0] DEVKIND_RESET  = 16'd2;

  // Configuration register indexes.
  localparam logic CFG_OFFERED = 1'b0;
  localparam logic CFG_DEVKIND = 1'b1;

  // Low byte of the register offsets; offset bit 8 marks config space.
  localparam logic [7:0] OFF_MAGIC       = 8'h00;
  localparam logic [7:0] OFF_VERSION     = 8'h04;
  localparam logic [7:0] OFF_DEVICE_ID   = 8'h08;
  localparam logic [7:0] OFF_VENDOR_ID   = 8'h0c;
  localparam logic [7:0] OFF_DEV_FEAT    = 8'h10;
  localparam logic [7:0] OFF_DEV_FEAT_SEL = 8'h14;
  localparam logic [7:0] OFF_DRV_FEAT    = 8'h20;
  localparam logic [7:0] OFF_DRV_FEAT_SEL = 8'h24;
  localparam logic [7:0] OFF_QUEUE_SEL   = 8'h30;
  localparam logic [7:0] OFF_QUEUE_MAX   = 8'h34;
  localparam logic [7:0] OFF_QUEUE_NUM   = 8'h38;
  localparam logic [7:0] OFF_QUEUE_READY = 8'h44;
  localparam logic [7:0] OFF_NOTIFY      = 8'h50;
  localparam logic [7:0] OFF_INT_STATUS  = 8'h60;
  localparam logic [7:0] OFF_INT_ACK     = 8'h64;
  localparam logic [7:0] OFF_STATUS      = 8'h70;
  localparam logic [7:0] OFF_DESC_LO     = 8'h80;
  localparam logic [7:0] OFF_DESC_HI     = 8'h84;
  localparam logic [7:0] OFF_AVAIL_LO    = 8'h90;
  localparam logic [7:0] OFF_AVAIL_HI    = 8'h94;
  localparam logic [7:0] OFF_USED_LO     = 8'ha0;
  localparam logic [7:0] OFF_USED_HI     = 8'ha4;

  typedef enum logic [1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_COMPLETE = 2'd2
  } mode_t;

  localparam int REQ_DATA_W = 96;
  localparam int RES_DATA_W = 240;

  typedef struct packed {
    mode_t       mode;
    logic [8:0]  offset;
    logic [31:0] write_data;
    logic [15:0] old_used;
    logic [15:0] new_used;
    logic [15:0] used_event;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        notify_valid;
    logic [2:0]  notify_queue;
    logic [8:0]  notify_ring_size;
    logic [63:0] notify_desc_addr;
    logic [63:0] notify_avail_addr;
    logic [63:0] notify_used_addr;
    logic        interrupt_pending;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/vmrb_pipe_reg.sv =====
// ----------------------------------------------------------------------------
// vmrb_pipe_reg
// One registered stream stage: holds a request until the next stage takes it
// and accepts a new one in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vmrb_pipe_reg #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vmrb_core.sv =====
// ----------------------------------------------------------------------------
// vmrb_core
// Register state of the device and the decode of one request: read mux,
// register writes, queue notify and the used-ring interrupt rule.
// ----------------------------------------------------------------------------
`default_nettype none

module vmrb_core
  import vmrb_pkg::*;
#(
  parameter int QUEUE_COUNT   = VMRB_QUEUE_COUNT,
  parameter int MAX_RING_SIZE = VMRB_MAX_RING_SIZE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        fire,
  input  wire req_t        req,
  output res_t             res
);

  localparam int QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int RSW = $clog2(MAX_RING_SIZE + 1);

  logic [63:0]    offered_features;
  logic [15:0]    device_kind;
  logic           feature_half_select;
  logic [63:0]    accepted_features;
  logic [2:0]     selected_queue;
  logic           queue_ready      [QUEUE_COUNT];
  logic [RSW-1:0] queue_ring_size  [QUEUE_COUNT];
  logic [63:0]    queue_desc_base  [QUEUE_COUNT];
  logic [63:0]    queue_avail_base [QUEUE_COUNT];
  logic [63:0]    queue_used_base  [QUEUE_COUNT];
  logic           ring_interrupt;
  logic           ring_interrupt_next;
  logic [31:0]    device_status_word;

  logic           is_cfg_space;
  logic           is_write;
  logic           is_notify;
  logic [QW-1:0]  sel_idx;
  logic [QW-1:0]  look_idx;
  logic           notify_in_range;
  logic           notify_hit;
  logic           qsel_in_range;
  logic           size_ok;
  logic [15:0]    ev_dist;
  logic [15:0]    new_dist;
  logic           need_irq;

  assign is_cfg_space    = req.offset[8];
  assign is_write        = (req.mode == MODE_WRITE) && !is_cfg_space;
  assign is_notify       = is_write && (req.offset[7:0] == OFF_NOTIFY);
  assign sel_idx         = selected_queue[QW-1:0];
  assign notify_in_range = req.write_data < 32'(QUEUE_COUNT);
  assign qsel_in_range   = req.write_data < 32'(QUEUE_COUNT);
  assign look_idx        = is_notify ? req.write_data[QW-1:0] : sel_idx;
  assign notify_hit      = is_notify && notify_in_range && queue_ready[look_idx];
  assign size_ok         = (req.write_data != 32'd0) &&
                           (req.write_data <= 32'(MAX_RING_SIZE));

  assign ev_dist  = req.new_used - req.used_event - 16'd1;
  assign new_dist = req.new_used - req.old_used;

  always_comb begin
    need_irq = (req.old_used != req.new_used);
    if (accepted_features[EVENT_IDX_BIT] && (ev_dist >= new_dist)) begin
      need_irq = 1'b0;
    end
  end

  always_comb begin
    ring_interrupt_next = ring_interrupt;
    if (req.mode == MODE_COMPLETE && need_irq) begin
      ring_interrupt_next = 1'b1;
    end else if (is_write && req.offset[7:0] == OFF_INT_ACK && req.write_data[0]) begin
      ring_interrupt_next = 1'b0;
    end
  end

  always_comb begin
    res                   = '0;
    res.interrupt_pending = ring_interrupt_next;
    if (req.mode == MODE_READ && !is_cfg_space) begin
      unique case (req.offset[7:0])
        OFF_MAGIC:       res.read_data = MAGIC_CODE;
        OFF_VERSION:     res.read_data = VERSION_CODE;
        OFF_DEVICE_ID:   res.read_data = {16'd0, device_kind};
        OFF_VENDOR_ID:   res.read_data = {16'd0, VENDOR_CODE};
        OFF_DEV_FEAT:    res.read_data = feature_half_select ? offered_features[63:32]
                                                             : offered_features[31:0];
        OFF_QUEUE_MAX:   res.read_data = 32'(MAX_RING_SIZE);
        OFF_QUEUE_READY: res.read_data = {31'd0, queue_ready[look_idx]};
        OFF_INT_STATUS:  res.read_data = {31'd0, ring_interrupt};
        OFF_STATUS:      res.read_data = device_status_word;
        OFF_DESC_LO:     res.read_data = queue_desc_base[look_idx][31:0];
        OFF_DESC_HI:     res.read_data = queue_desc_base[look_idx][63:32];
        OFF_AVAIL_LO:    res.read_data = queue_avail_base[look_idx][31:0];
        OFF_AVAIL_HI:    res.read_data = queue_avail_base[look_idx][63:32];
        OFF_USED_LO:     res.read_data = queue_used_base[look_idx][31:0];
        OFF_USED_HI:     res.read_data = queue_used_base[look_idx][63:32];
        default:         res.read_data = 32'd0;
      endcase
    end
    if (notify_hit) begin
      res.notify_valid      = 1'b1;
      res.notify_queue      = req.write_data[2:0];
      res.notify_ring_size  = 9'(queue_ring_size[look_idx]);
      res.notify_desc_addr  = queue_desc_base[look_idx];
      res.notify_avail_addr = queue_avail_base[look_idx];
      res.notify_used_addr  = queue_used_base[look_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offered_features <= OFFERED_RESET;
      device_kind      <= DEVKIND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFERED: offered_features <= cfg_data;
        CFG_DEVKIND: device_kind      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_half_select <= 1'b0;
      accepted_features   <= '0;
      selected_queue      <= '0;
      ring_interrupt      <= 1'b0;
      device_status_word  <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        queue_ready[i]      <= 1'b0;
        queue_ring_size[i]  <= '0;
        queue_desc_base[i]  <= '0;
        queue_avail_base[i] <= '0;
        queue_used_base[i]  <= '0;
      end
    end else if (fire) begin
      ring_interrupt <= ring_interrupt_next;
      if (is_write) begin
        unique case (req.offset[7:0]) inside
          OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL: begin
            feature_half_select <= (req.write_data != 32'd0);
          end
          OFF_DRV_FEAT: begin
            if (feature_half_select) begin
              accepted_features[63:32] <= req.write_data;
            end else begin
              accepted_features[31:0] <= req.write_data;
            end
          end
          OFF_QUEUE_SEL: begin
            if (qsel_in_range) begin
              selected_queue <= req.write_data[2:0];
            end
          end
          OFF_QUEUE_NUM: begin
            queue_ring_size[sel_idx] <= size_ok ? req.write_data[RSW-1:0] : '0;
          end
          OFF_QUEUE_READY: queue_ready[sel_idx] <= req.write_data[0];
          OFF_STATUS:      device_status_word <= req.write_data;
          OFF_DESC_LO:     queue_desc_base[sel_idx][31:0]   <= req.write_data;
          OFF_DESC_HI:     queue_desc_base[sel_idx][63:32]  <= req.write_data;
          OFF_AVAIL_LO:    queue_avail_base[sel_idx][31:0]  <= req.write_data;
          OFF_AVAIL_HI:    queue_avail_base[sel_idx][63:32] <= req.write_data;
          OFF_USED_LO:     queue_used_base[sel_idx][31:0]   <= req.write_data;
          OFF_USED_HI:     queue_used_base[sel_idx][63:32]  <= req.write_data;
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_irq_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(ring_interrupt) |-> $past(fire && req.mode == MODE_COMPLETE))
    else $error("interrupt raised without a completion");

  a_irq_fall: assert property (@(posedge clk) disable iff (rst)
    ($fell(ring_interrupt) && !$past(rst)) |->
      $past(fire && is_write && req.offset[7:0] == OFF_INT_ACK && req.write_data[0]))
    else $error("interrupt cleared without an acknowledge");

  a_qsel_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, selected_queue} < 4'(QUEUE_COUNT))
    else $error("selected queue out of range");

  a_notify_src: assert property (@(posedge clk) disable iff (rst)
    res.notify_valid |-> (req.mode == MODE_WRITE && req.offset == {1'b0, OFF_NOTIFY}))
    else $error("notify outside a notify write");
`endif

endmodule

`default_nettype wire

// ===== sv/virtio_mmio_register_block_unit.sv =====
// ----------------------------------------------------------------------------
// virtio_mmio_register_block_unit
// Register front end of a virtio-mmio version 2 device: register reads and
// writes, queue notify and used-ring completion reports.
// ----------------------------------------------------------------------------
//   Channel   Direction  Contents
//   s_axis    in         one request: read, write or completion report
//   m_axis    out        one result per request
//   cfg       in         offered feature set and device ID
//
// One request per cycle is taken unless m_axis stalls; requests are held in
// the input register and results in the result register around the decode
// logic. Reset restores all register state to its defaults. When m_axis is
// stalled the result is held, one more request is taken into the input
// register, and then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module virtio_mmio_register_block_unit
  import vmrb_pkg::*;
#(
  parameter int QUEUE_COUNT   = VMRB_QUEUE_COUNT,
  parameter int MAX_RING_SIZE = VMRB_MAX_RING_SIZE
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // offset[8:0], write_data[40:9], old_used[56:41], new_used[72:57],
  // used_event[88:73], zero fill above
  input  wire logic [REQ_DATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // read_data[31:0], notify_queue[34:32], notify_ring_size[43:35],
  // notify_desc_addr[107:44], notify_avail_addr[171:108],
  // notify_used_addr[235:172], interrupt_pending[236], zero fill above
  output logic [RES_DATA_W-1:0]      m_axis_tdata,
  // notify_valid[0]
  output logic [0:0]                 m_axis_tuser,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [63:0]           cfg_data
);

  localparam int IN_W  = REQ_DATA_W + 2;
  localparam int OUT_W = RES_DATA_W + 1;

  logic [IN_W-1:0]  in_word;
  logic [IN_W-1:0]  req_word;
  logic             req_valid;
  logic             res_ready;
  logic             fire;
  req_t             req;
  res_t             res;
  logic [OUT_W-1:0] res_word;
  logic [OUT_W-1:0] out_word;

  assign in_word = {s_axis_tuser, s_axis_tdata};

  vmrb_pipe_reg #(.W(IN_W)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_word),
    .out_valid (req_valid),
    .out_ready (res_ready),
    .out_data  (req_word)
  );

  assign req.mode       = mode_t'(req_word[IN_W-1 -: 2]);
  assign req.offset     = req_word[8:0];
  assign req.write_data = req_word[40:9];
  assign req.old_used   = req_word[56:41];
  assign req.new_used   = req_word[72:57];
  assign req.used_event = req_word[88:73];

  assign fire = req_valid && res_ready;

  vmrb_core #(
    .QUEUE_COUNT   (QUEUE_COUNT),
    .MAX_RING_SIZE (MAX_RING_SIZE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .req       (req),
    .res       (res)
  );

  assign res_word = {res.notify_valid, 3'd0, res.interrupt_pending,
                     res.notify_used_addr, res.notify_avail_addr,
                     res.notify_desc_addr, res.notify_ring_size,
                     res.notify_queue, res.read_data};

  vmrb_pipe_reg #(.W(OUT_W)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (res_ready),
    .in_data   (res_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_word)
  );

  assign m_axis_tdata = out_word[RES_DATA_W-1:0];
  assign m_axis_tuser = out_word[OUT_W-1 -: 1];

endmodule

`default_nettype wire

// ===== dv/virtio_mmio_register_block_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// virtio_mmio_register_block_unit_tb
// Self-checking bench for the virtio-mmio register front end. A directed
// table opens the run. Random register traffic, queue setup bursts with a
// notify, and completion reports follow under several feature and device ID
// settings. Each request is scored against a cycle-free model of the
// register file, with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------

module virtio_mmio_register_block_unit_tb;
  import vmrb_pkg::*;

  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam logic [7:0] OFF_CFG_GEN    = 8'hfc;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         N_DIRECTED     = 30;
  localparam int         N_PHASES       = 5;
  localparam int         PHASE_REQUESTS = 200;
  localparam int         N_REG_OFFS     = 23;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  offset;
    logic [31:0] write_data;
    logic [15:0] old_used;
    logic [15:0] new_used;
    logic [15:0] used_event;
    logic        typed;
    logic [31:0] typed_rd;
  } mmio_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [REQ_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RES_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_OFFERED;
  logic [63:0]           cfg_data = '0;

  // Register file as the driver sees it.
  logic [63:0] cfg_offered = OFFERED_RESET;
  logic [15:0] cfg_kind    = DEVKIND_RESET;
  logic        feat_hi_sel = 1'b0;
  logic [63:0] drv_features = '0;
  logic [2:0]  cur_queue = '0;
  logic        q_ready [VMRB_QUEUE_COUNT] = '{default: 1'b0};
  logic [8:0]  q_size  [VMRB_QUEUE_COUNT] = '{default: '0};
  logic [63:0] q_desc  [VMRB_QUEUE_COUNT] = '{default: '0};
  logic [63:0] q_avail [VMRB_QUEUE_COUNT] = '{default: '0};
  logic [63:0] q_used  [VMRB_QUEUE_COUNT] = '{default: '0};
  logic        irq = 1'b0;
  logic [31:0] dev_status = '0;

  mmio_req_t request_backlog [$];
  res_t      pending_responses [$];
  mmio_req_t in_flight = '0;
  bit        req_taken = 1'b0;
  int        idle_pct = 22;
  int        requests_sent = 0;
  int        requests_taken = 0;
  int        responses_seen = 0;
  int        notifies_expected = 0;
  int        irq_raises = 0;
  int        errors = 0;
  int        stall_cycles = 0;

  logic [7:0] reg_offsets [N_REG_OFFS] = '{
    OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID, OFF_DEV_FEAT,
    OFF_DEV_FEAT_SEL, OFF_DRV_FEAT, OFF_DRV_FEAT_SEL, OFF_QUEUE_SEL,
    OFF_QUEUE_MAX, OFF_QUEUE_NUM, OFF_QUEUE_READY, OFF_NOTIFY, OFF_INT_STATUS,
    OFF_INT_ACK, OFF_STATUS, OFF_DESC_LO, OFF_DESC_HI, OFF_AVAIL_LO,
    OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI, OFF_CFG_GEN
  };

  // mode, offset, write_data, old_used, new_used, used_event, typed, read_data
  mmio_req_t directed_rows [N_DIRECTED] = '{
    '{MODE_READ,     {1'b0, OFF_MAGIC},        32'h0, 16'h0, 16'h0, 16'h0, 1'b1, MAGIC_CODE},
    '{MODE_READ,     {1'b0, OFF_VERSION},      32'h0, 16'h0, 16'h0, 16'h0, 1'b1, VERSION_CODE},
    '{MODE_READ,     {1'b0, OFF_DEVICE_ID},    32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'd2},
    '{MODE_READ,     {1'b0, OFF_VENDOR_ID},    32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'hf003},
    '{MODE_READ,     {1'b0, OFF_DEV_FEAT},     32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h2000_0000},
    '{MODE_WRITE,    {1'b0, OFF_DEV_FEAT_SEL}, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_READ,     {1'b0, OFF_DEV_FEAT},     32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h1},
    '{MODE_READ,     {1'b0, OFF_QUEUE_MAX},    32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'd256},
    '{MODE_WRITE,    {1'b0, OFF_DRV_FEAT},     32'hffff_ffff, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_DRV_FEAT_SEL}, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_DRV_FEAT},     32'h2000_0000, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_QUEUE_SEL},    32'd8, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_QUEUE_NUM},    32'd257, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_QUEUE_SEL},    32'd7, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_QUEUE_NUM},    32'd256, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_DESC_HI},      32'hffff_ffff, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_USED_LO},      32'hffff_ffff, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_QUEUE_READY},  32'hffff_ffff, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_READ,     {1'b0, OFF_QUEUE_READY},  32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h1},
    '{MODE_WRITE,    {1'b0, OFF_NOTIFY},       32'd7, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_NOTIFY},       32'd8, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_NOTIFY},       32'd0, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_COMPLETE, 9'h0, 32'h0, 16'd5, 16'd5, 16'd4, 1'b0, 32'h0},
    '{MODE_COMPLETE, 9'h0, 32'h0, 16'h0, 16'hffff, 16'hffff, 1'b0, 32'h0},
    '{MODE_COMPLETE, 9'h0, 32'h0, 16'hfffe, 16'h0001, 16'hffff, 1'b0, 32'h0},
    '{MODE_READ,     {1'b0, OFF_INT_STATUS},   32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h1},
    '{MODE_WRITE,    {1'b0, OFF_INT_ACK},      32'hffff_fffe, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_WRITE,    {1'b0, OFF_INT_ACK},      32'h1, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0},
    '{MODE_READ,     9'h1ff,                   32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h0},
    '{MODE_SPARE,    {1'b0, OFF_MAGIC},        32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff,
      1'b1, 32'h0}
  };

  virtio_mmio_register_block_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic predict_mmio_response(input mmio_req_t r, output res_t o);
    logic [2:0]  q;
    logic [2:0]  nq;
    logic [31:0] v;
    logic [15:0] gap_event;
    logic [15:0] gap_batch;
    logic        want_irq;
    q = cur_queue;
    v = r.write_data;
    nq = v[2:0];
    o = '0;
    if (r.mode == MODE_READ && !r.offset[8]) begin
      case (r.offset[7:0])
        OFF_MAGIC:       o.read_data = MAGIC_CODE;
        OFF_VERSION:     o.read_data = VERSION_CODE;
        OFF_DEVICE_ID:   o.read_data = {16'd0, cfg_kind};
        OFF_VENDOR_ID:   o.read_data = {16'd0, VENDOR_CODE};
        OFF_DEV_FEAT:    o.read_data = feat_hi_sel ? cfg_offered[63:32] : cfg_offered[31:0];
        OFF_QUEUE_MAX:   o.read_data = 32'(VMRB_MAX_RING_SIZE);
        OFF_QUEUE_READY: o.read_data = {31'd0, q_ready[q]};
        OFF_INT_STATUS:  o.read_data = {31'd0, irq};
        OFF_STATUS:      o.read_data = dev_status;
        OFF_DESC_LO:     o.read_data = q_desc[q][31:0];
        OFF_DESC_HI:     o.read_data = q_desc[q][63:32];
        OFF_AVAIL_LO:    o.read_data = q_avail[q][31:0];
        OFF_AVAIL_HI:    o.read_data = q_avail[q][63:32];
        OFF_USED_LO:     o.read_data = q_used[q][31:0];
        OFF_USED_HI:     o.read_data = q_used[q][63:32];
        default:         o.read_data = '0;
      endcase
    end else if (r.mode == MODE_WRITE && !r.offset[8]) begin
      case (r.offset[7:0])
        OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL: feat_hi_sel = (v != 0);
        OFF_DRV_FEAT: begin
          if (feat_hi_sel) drv_features[63:32] = v;
          else drv_features[31:0] = v;
        end
        OFF_QUEUE_SEL: begin
          if (v < VMRB_QUEUE_COUNT) cur_queue = nq;
        end
        OFF_QUEUE_NUM: begin
          q_size[q] = (v >= 1 && v <= VMRB_MAX_RING_SIZE) ? v[8:0] : 9'd0;
        end
        OFF_QUEUE_READY: q_ready[q] = v[0];
        OFF_NOTIFY: begin
          if (v < VMRB_QUEUE_COUNT && q_ready[nq]) begin
            o.notify_valid      = 1'b1;
            o.notify_queue      = nq;
            o.notify_ring_size  = q_size[nq];
            o.notify_desc_addr  = q_desc[nq];
            o.notify_avail_addr = q_avail[nq];
            o.notify_used_addr  = q_used[nq];
          end
        end
        OFF_INT_ACK: begin
          if (v[0]) irq = 1'b0;
        end
        OFF_STATUS:   dev_status = v;
        OFF_DESC_LO:  q_desc[q][31:0] = v;
        OFF_DESC_HI:  q_desc[q][63:32] = v;
        OFF_AVAIL_LO: q_avail[q][31:0] = v;
        OFF_AVAIL_HI: q_avail[q][63:32] = v;
        OFF_USED_LO:  q_used[q][31:0] = v;
        OFF_USED_HI:  q_used[q][63:32] = v;
        default: ;
      endcase
    end else if (r.mode == MODE_COMPLETE && r.old_used != r.new_used) begin
      // With the event index accepted, interrupt only when used_event lies in the new batch.
      want_irq = 1'b1;
      if (drv_features[EVENT_IDX_BIT]) begin
        gap_event = r.new_used - r.used_event - 16'd1;
        gap_batch = r.new_used - r.old_used;
        want_irq = gap_event < gap_batch;
      end
      if (want_irq && !irq) irq_raises++;
      if (want_irq) irq = 1'b1;
    end
    o.interrupt_pending = irq;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      errors++;
    end
  endtask

  // Scoring at the rising edge.
  always @(posedge clk) begin : score_responses
    res_t want;
    res_t seen;
    if (!rst) begin
      req_taken = s_axis_tvalid && s_axis_tready;
      if (req_taken) begin
        predict_mmio_response(in_flight, want);
        if (in_flight.typed) want.read_data = in_flight.typed_rd;
        if (want.notify_valid) notifies_expected++;
        pending_responses.push_back(want);
        requests_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.read_data         = m_axis_tdata[31:0];
        seen.notify_valid      = m_axis_tuser[0];
        seen.notify_queue      = m_axis_tdata[34:32];
        seen.notify_ring_size  = m_axis_tdata[43:35];
        seen.notify_desc_addr  = m_axis_tdata[107:44];
        seen.notify_avail_addr = m_axis_tdata[171:108];
        seen.notify_used_addr  = m_axis_tdata[235:172];
        seen.interrupt_pending = m_axis_tdata[236];
        responses_seen++;
        if (pending_responses.size() == 0) begin
          $display("%0t ns: response with none expected, actual %h", $time, seen);
          errors++;
        end else begin
          want = pending_responses.pop_front();
          check_field("read_data", 64'(want.read_data), 64'(seen.read_data));
          check_field("notify_valid", 64'(want.notify_valid), 64'(seen.notify_valid));
          check_field("notify_queue", 64'(want.notify_queue), 64'(seen.notify_queue));
          check_field("notify_ring_size", 64'(want.notify_ring_size),
                      64'(seen.notify_ring_size));
          check_field("notify_desc_addr", want.notify_desc_addr, seen.notify_desc_addr);
          check_field("notify_avail_addr", want.notify_avail_addr, seen.notify_avail_addr);
          check_field("notify_used_addr", want.notify_used_addr, seen.notify_used_addr);
          check_field("interrupt_pending", 64'(want.interrupt_pending),
                      64'(seen.interrupt_pending));
        end
      end
      if (req_taken || (m_axis_tvalid && m_axis_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no request or response moved for %0d cycles", $time, stall_cycles);
        $display("[virtio_mmio_register_block_unit] ERROR");
        $finish;
      end
    end
  end

  // Driving at the falling edge.
  always @(negedge clk) begin : drive_requests
    mmio_req_t nxt;
    logic      go;
    go = s_axis_tvalid && !req_taken;
    nxt = in_flight;
    if (!rst && !go && request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
      nxt = request_backlog.pop_front();
      go = 1'b1;
      requests_sent++;
    end
    s_axis_tvalid <= go;
    in_flight     <= nxt;
    s_axis_tdata  <= {7'd0, nxt.used_event, nxt.new_used, nxt.old_used,
                      nxt.write_data, nxt.offset};
    s_axis_tuser  <= nxt.mode;
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic wait_quiet();
    do @(negedge clk);
    while (request_backlog.size() != 0 || requests_sent != requests_taken ||
           pending_responses.size() != 0);
  endtask

  task automatic apply_setting(input logic idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_OFFERED) cfg_offered = val;
    else cfg_kind = val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_write(input logic [7:0] off, input logic [31:0] val);
    mmio_req_t r;
    r = '0;
    r.mode       = MODE_WRITE;
    r.offset     = {1'b0, off};
    r.write_data = val;
    r.old_used   = 16'($urandom);
    r.new_used   = 16'($urandom);
    r.used_event = 16'($urandom);
    request_backlog.push_back(r);
  endtask

  // A driver-style queue bring-up ending in a notify.
  task automatic push_queue_setup();
    logic [2:0] q;
    q = 3'($urandom_range(7));
    push_write(OFF_QUEUE_SEL, 32'(q));
    push_write(OFF_QUEUE_NUM, ($urandom_range(3) == 0) ? $urandom
                                : $urandom_range(VMRB_MAX_RING_SIZE, 1));
    push_write(OFF_DESC_LO, $urandom);
    push_write(OFF_DESC_HI, $urandom);
    push_write(OFF_AVAIL_LO, $urandom);
    push_write(OFF_AVAIL_HI, $urandom);
    push_write(OFF_USED_LO, $urandom);
    push_write(OFF_USED_HI, $urandom);
    push_write(OFF_QUEUE_READY, 32'($urandom_range(4) != 0));
    push_write(OFF_NOTIFY, ($urandom_range(4) == 0) ? $urandom_range(9) : 32'(q));
  endtask

  task automatic push_random_request();
    mmio_req_t r;
    int        roll;
    r = '0;
    r.write_data = $urandom;
    r.old_used   = 16'($urandom);
    r.new_used   = 16'($urandom);
    r.used_event = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 38) r.mode = MODE_READ;
    else if (roll < 80) r.mode = MODE_WRITE;
    else if (roll < 97) r.mode = MODE_COMPLETE;
    else r.mode = MODE_SPARE;
    roll = $urandom_range(99);
    if (roll < 80) r.offset = {1'b0, reg_offsets[$urandom_range(N_REG_OFFS - 1)]};
    else if (roll < 90) r.offset = {1'b1, 8'($urandom)};
    else r.offset = 9'($urandom);
    case ($urandom_range(3))
      0: ;
      1: r.write_data = $urandom_range(9);
      2: r.write_data = $urandom_range(300);
      default: r.write_data = $urandom_range(1) ? 32'hffff_ffff : 32'd1 << $urandom_range(31);
    endcase
    // Most completions are short batches with used_event near the old index.
    if (r.mode == MODE_COMPLETE && $urandom_range(3) != 0) begin
      r.new_used   = r.old_used + 16'($urandom_range(6));
      r.used_event = r.old_used + 16'($urandom_range(8)) - 16'd2;
    end
    request_backlog.push_back(r);
  endtask

  initial begin : run_sequence
    logic [63:0] phase_offered [N_PHASES];
    logic [15:0] phase_kind [N_PHASES];
    int          made;
    phase_offered = '{64'h0, 64'hffff_ffff_ffff_ffff, {$urandom, $urandom},
                      {$urandom, $urandom}, OFFERED_RESET};
    phase_kind    = '{16'hffff, 16'h0, 16'($urandom), 16'($urandom), DEVKIND_RESET};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) request_backlog.push_back(directed_rows[i]);
    wait_quiet();

    for (int p = 0; p < N_PHASES; p++) begin
      apply_setting(CFG_OFFERED, phase_offered[p]);
      apply_setting(CFG_DEVKIND, 64'(phase_kind[p]));
      idle_pct = (p == 2) ? 0 : 22;
      made = 0;
      while (made < PHASE_REQUESTS) begin
        if ($urandom_range(99) < 12) begin
          push_queue_setup();
          made += 10;
        end else begin
          push_random_request();
          made++;
        end
      end
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d requests under %0d feature and device ID settings.",
             requests_taken, N_PHASES + 1);
    $display("Scored %0d responses, %0d of them valid notifies; interrupt raised %0d times.",
             responses_seen, notifies_expected, irq_raises);
    if (errors == 0) begin
      $display("[virtio_mmio_register_block_unit] OK");
    end else begin
      $display("[virtio_mmio_register_block_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vmrb_pkg.sv
sv/vmrb_pipe_reg.sv
sv/vmrb_core.sv
sv/virtio_mmio_register_block_unit.sv
dv/virtio_mmio_register_block_unit_tb.sv
